// File: hw/rtl/nce_pkg.sv
// Package for the noise channel: widths, codes, state and step unit types.
// No dependencies; used by the interfaces, the step unit and the top level.
package nce_pkg;

  localparam int LENGTH_RELOAD_DEF    = 64;
  localparam int CYCLE_INPUT_BITS_DEF = 8;

  localparam int ACC_W      = 23;   // cycle accumulator
  localparam int LFSR_W     = 15;
  localparam int PERIOD_W   = 22;   // 112 << 15 fits
  localparam int BASE_W     = 7;
  localparam int LEVEL_W    = 4;
  localparam int PACE_W     = 3;
  localparam int SAMPLE_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 15'h7FFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENVELOPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_EN = 2'd2;

  typedef enum logic [1:0] {
    REQ_ADVANCE  = 2'd0,
    REQ_TRIGGER  = 2'd1,
    REQ_LENGTH   = 2'd2,
    REQ_ENVELOPE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_STEP = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic              take;      // a full period is held
    logic [ACC_W-1:0]  acc_nxt;
    logic [LFSR_W-1:0] lfsr_nxt;
  } step_res_t;

endpackage

// File: hw/rtl/nce_in_if.sv
// Input channel of the noise channel: valid/ready plus event payload.
// Depends on nce_pkg for the default cycle count width.
interface nce_in_if #(
  parameter int CYCLE_INPUT_BITS = nce_pkg::CYCLE_INPUT_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [CYCLE_INPUT_BITS-1:0] cycle_count;

  modport source (output valid, req_type, cycle_count, input ready);
  modport sink   (input valid, req_type, cycle_count, output ready);
endinterface

// File: hw/rtl/nce_out_if.sv
// Result channel of the noise channel: valid/ready plus sample and active flag.
// Depends on nce_pkg for the sample width.
interface nce_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [nce_pkg::SAMPLE_W-1:0] sample;
  logic                                active;

  modport source (output valid, sample, active, input ready);
  modport sink   (input valid, sample, active, output ready);
endinterface

// File: hw/rtl/nce_step_unit.sv
// Step unit: period decode, compare/subtract on the accumulator, LFSR step.
// Depends on nce_pkg.
module nce_step_unit (
  input  logic [nce_pkg::CFG_DATA_W-1:0] noise_setting,
  input  logic [nce_pkg::ACC_W-1:0]      acc,
  input  logic [nce_pkg::LFSR_W-1:0]     lfsr,
  output nce_pkg::step_res_t             res
);
  import nce_pkg::*;

  logic [2:0]          code;
  logic [3:0]          shift;
  logic [BASE_W-1:0]   base;
  logic [PERIOD_W-1:0] period;
  logic [ACC_W-1:0]    period_ext;
  logic                fb;
  logic [LFSR_W-1:0]   shifted;

  always_comb begin
    code       = noise_setting[2:0];
    shift      = noise_setting[7:4];
    base       = (code == 3'd0) ? BASE_W'(8) : {code, 4'b0000};
    period     = PERIOD_W'(base) << shift;
    period_ext = {1'b0, period};

    fb      = lfsr[0] ^ lfsr[1];
    shifted = {fb, lfsr[LFSR_W-1:1]};
    if (noise_setting[3]) begin
      shifted[6] = fb;  // short mode
    end

    res.take     = (acc >= period_ext);
    res.acc_nxt  = acc - period_ext;
    res.lfsr_nxt = shifted;
  end
endmodule

// File: hw/rtl/noise_channel_lfsr_envelope.sv
// Noise voice: 15-bit LFSR clocked from a cycle accumulator, envelope, length counter.
// Trigger/length/envelope: the event is applied on the input transfer, then the done state
// loads the result register. Advance: the cycle count is added to the accumulator, then
//   k = floor((cycle_total + cycle_count) / period) LFSR steps follow, one per cycle.
// One item in flight; in_ch.ready is high only while idle; a stalled result waits in done.
// Synchronous active-low reset: LFSR to all ones, all else but sample/active cleared.
module noise_channel_lfsr_envelope #(
  parameter int LENGTH_RELOAD    = nce_pkg::LENGTH_RELOAD_DEF,
  parameter int CYCLE_INPUT_BITS = nce_pkg::CYCLE_INPUT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  nce_in_if.sink                           in_ch,
  nce_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [nce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nce_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import nce_pkg::*;

  localparam int LEN_W = $clog2(LENGTH_RELOAD + 1);

  // settings
  logic [CFG_DATA_W-1:0] env_set_r, env_set_nxt;
  logic [CFG_DATA_W-1:0] noise_set_r, noise_set_nxt;
  logic                  len_en_r, len_en_nxt;

  // voice state
  state_t              state_r, state_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [LEN_W-1:0]    len_left_r, len_left_nxt;
  logic [PACE_W-1:0]   env_cd_r, env_cd_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic                conv_on_r, conv_on_nxt;
  logic                voice_on_r, voice_on_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_active_r, out_active_nxt;

  step_res_t          step;
  logic               in_xfer;
  logic               out_load;
  logic [PACE_W-1:0]  pace;
  logic [PACE_W-1:0]  cd_dec;
  logic [SAMPLE_W-1:0] mag;

  nce_step_unit u_step (
    .noise_setting (noise_set_r),
    .acc           (acc_r),
    .lfsr          (lfsr_r),
    .res           (step)
  );

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_xfer       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.active = out_active_r;

  assign pace = env_set_r[2:0];
  assign mag  = {1'b0, level_r};

  always_comb begin
    env_set_nxt    = env_set_r;
    noise_set_nxt  = noise_set_r;
    len_en_nxt     = len_en_r;
    state_nxt      = state_r;
    lfsr_nxt       = lfsr_r;
    acc_nxt        = acc_r;
    len_left_nxt   = len_left_r;
    env_cd_nxt     = env_cd_r;
    level_nxt      = level_r;
    conv_on_nxt    = conv_on_r;
    voice_on_nxt   = voice_on_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;
    out_load       = 1'b0;
    cd_dec         = (env_cd_r != '0) ? env_cd_r - PACE_W'(1) : '0;

    // config writes are for the user to make only while idle; the block does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENVELOPE:  env_set_nxt   = cfg_wdata;
        CFG_NOISE:     noise_set_nxt = cfg_wdata;
        CFG_LENGTH_EN: len_en_nxt    = cfg_wdata[0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DONE;
          case (req_type_t'(in_ch.req_type))
            REQ_ADVANCE: begin
              // sum wraps at the accumulator width
              acc_nxt   = acc_r + {{(ACC_W-CYCLE_INPUT_BITS){1'b0}}, in_ch.cycle_count};
              state_nxt = ST_STEP;
            end
            REQ_TRIGGER: begin
              if (len_left_r == '0) begin
                len_left_nxt = LEN_W'(LENGTH_RELOAD);
              end
              env_cd_nxt   = pace;
              level_nxt    = env_set_r[7:4];
              lfsr_nxt     = LFSR_SEED;
              conv_on_nxt  = (env_set_r[7:3] != '0);
              voice_on_nxt = (env_set_r[7:3] != '0);
            end
            REQ_LENGTH: begin
              if (len_en_r && (len_left_r != '0)) begin
                len_left_nxt = len_left_r - LEN_W'(1);
                if (len_left_r == LEN_W'(1)) begin
                  voice_on_nxt = 1'b0;
                end
              end
            end
            REQ_ENVELOPE: begin
              if (pace != '0) begin
                env_cd_nxt = cd_dec;
                if (cd_dec == '0) begin
                  env_cd_nxt = pace;
                  if (env_set_r[3]) begin
                    if (level_r != 4'hF) level_nxt = level_r + LEVEL_W'(1);
                  end else if (level_r != '0) begin
                    level_nxt = level_r - LEVEL_W'(1);
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        // one period taken per cycle
        if (step.take) begin
          acc_nxt  = step.acc_nxt;
          lfsr_nxt = step.lfsr_nxt;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_active_nxt = voice_on_r;
      if (voice_on_r && conv_on_r) begin
        out_sample_nxt = lfsr_r[0] ? -$signed(mag) : $signed(mag);
      end else begin
        out_sample_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_set_r   <= '0;
      noise_set_r <= '0;
      len_en_r    <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      acc_r       <= '0;
      len_left_r  <= '0;
      env_cd_r    <= '0;
      level_r     <= '0;
      conv_on_r   <= 1'b0;
      voice_on_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_set_r   <= env_set_nxt;
      noise_set_r <= noise_set_nxt;
      len_en_r    <= len_en_nxt;
      lfsr_r      <= lfsr_nxt;
      acc_r       <= acc_nxt;
      len_left_r  <= len_left_nxt;
      env_cd_r    <= env_cd_nxt;
      level_r     <= level_nxt;
      conv_on_r   <= conv_on_nxt;
      voice_on_r  <= voice_on_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
  end
endmodule

// File: hw/rtl/nce_checker.sv
// Port-level checks for the noise channel, bound to the top level.
// Depends on nce_pkg and noise_channel_lfsr_envelope.
module nce_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [nce_pkg::SAMPLE_W-1:0] out_sample,
  input logic                                out_active
);
  import nce_pkg::*;

  // one item at a time: a transfer closes the input until the result is made
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  // a silent voice gives a zero sample
  a_off_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_active) |-> (out_sample == '0))
    else $error("nonzero sample while inactive");

  // sample stays within plus or minus 15
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample != -SAMPLE_W'(16)))
    else $error("sample out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample) && $stable(out_active)))
    else $error("result changed while stalled");
endmodule

bind noise_channel_lfsr_envelope nce_checker u_nce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.sample),
  .out_active (out_ch.active)
);

// File: sim/noise_channel_lfsr_envelope_tb.sv
// Self-checking testbench for the noise voice: LFSR stepping, envelope, length counter.
// Depends on nce_pkg, nce_in_if, nce_out_if and noise_channel_lfsr_envelope from hw/rtl.
`timescale 1ns / 100ps

module noise_channel_lfsr_envelope_tb;
  import nce_pkg::*;

  localparam int CYC_W        = CYCLE_INPUT_BITS_DEF;
  localparam int CYCLE_LIMIT  = 2_000_000;  // slowest legal run is far below this
  localparam int SETTLE       = 4;          // idle cycles before a register write
  localparam int END_WAIT     = 200_000;    // bound on the final drain
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
  } voice_out_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nce_in_if #(.CYCLE_INPUT_BITS(CYC_W)) in_ch ();
  nce_out_if                            out_ch ();

  noise_channel_lfsr_envelope #(
    .LENGTH_RELOAD    (LENGTH_RELOAD_DEF),
    .CYCLE_INPUT_BITS (CYC_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predicted voice state; mirrors the block after every accepted transfer.
  // ---------------------------------------------------------------------------
  logic [7:0]         env_reg;
  logic [7:0]         noise_reg;
  logic               len_en_reg;
  logic [LFSR_W-1:0]  voice_lfsr;
  logic [ACC_W-1:0]   cycle_acc;
  logic [6:0]         length_count;
  logic [PACE_W-1:0]  env_count;
  logic [LEVEL_W-1:0] env_level;
  logic               dac_live;
  logic               voice_live;

  voice_out_t expected_outputs[$];  // predicted samples, oldest first

  int mismatches;
  int results_seen;
  int send_idle_pct;   // chance per cycle that the sender holds back
  int recv_stall_pct;  // chance per cycle that the receiver drops ready
  int holdoff_req;     // long receiver stall, handed to the result process
  int elapsed_cycles;

  // Step period: code 0 gives 8, otherwise code*16, then shifted by the clock shift.
  function automatic logic [PERIOD_W-1:0] noise_period(input logic [7:0] setting);
    logic [PERIOD_W-1:0] base;
    base = (setting[2:0] == 3'd0) ? PERIOD_W'(8) : PERIOD_W'({setting[2:0], 4'b0000});
    return base << setting[7:4];
  endfunction

  task automatic voice_model_reset();
    env_reg      = '0;
    noise_reg    = '0;
    len_en_reg   = 1'b0;
    voice_lfsr   = LFSR_SEED;
    cycle_acc    = '0;
    length_count = '0;
    env_count    = '0;
    env_level    = '0;
    dac_live     = 1'b0;
    voice_live   = 1'b0;
  endtask

  // Applies one event to the predicted state and queues the sample it yields.
  task automatic voice_model_step(input req_type_t kind, input logic [CYC_W-1:0] cycles);
    logic [ACC_W:0]      acc;
    logic [ACC_W:0]      period;
    logic                fb;
    voice_out_t          res;
    case (kind)
      REQ_ADVANCE: begin
        period = (ACC_W+1)'(noise_period(noise_reg));
        acc = {1'b0, cycle_acc} + (ACC_W+1)'(cycles);
        acc[ACC_W] = 1'b0;  // accumulator wraps at its width
        // every full period held steps the LFSR, remainder carries over
        while (acc >= period) begin
          acc -= period;
          fb = voice_lfsr[0] ^ voice_lfsr[1];
          voice_lfsr = {fb, voice_lfsr[LFSR_W-1:1]};
          if (noise_reg[3]) voice_lfsr[6] = fb;  // short mode
        end
        cycle_acc = acc[ACC_W-1:0];
      end
      REQ_TRIGGER: begin
        if (length_count == '0) length_count = 7'(LENGTH_RELOAD_DEF);
        env_count  = env_reg[2:0];
        env_level  = env_reg[7:4];
        voice_lfsr = LFSR_SEED;
        dac_live   = |env_reg[7:3];
        voice_live = dac_live;
      end
      REQ_LENGTH: begin
        if (len_en_reg && length_count != '0) begin
          length_count = length_count - 7'd1;
          if (length_count == '0) voice_live = 1'b0;
        end
      end
      REQ_ENVELOPE: begin
        if (env_reg[2:0] != '0) begin
          if (env_count != '0) env_count = env_count - PACE_W'(1);
          if (env_count == '0) begin
            env_count = env_reg[2:0];
            if (env_reg[3]) begin
              if (env_level != 4'hF) env_level = env_level + LEVEL_W'(1);
            end else if (env_level != 4'h0) begin
              env_level = env_level - LEVEL_W'(1);
            end
          end
        end
      end
      default: ;
    endcase
    res.sample = '0;
    if (voice_live && dac_live) begin
      res.sample = voice_lfsr[0] ? -{1'b0, env_level} : {1'b0, env_level};
    end
    res.active = voice_live;
    expected_outputs.push_back(res);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("ERROR @%0t result %0d: %s", $time, results_seen, what);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    elapsed_cycles = 0;
    while (elapsed_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      elapsed_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: checks each transfer against the oldest prediction and drives
  // ready. A long hold-off requested by a test is counted down here.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    voice_out_t want;
    int         stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_outputs.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding");
        end else begin
          want = expected_outputs.pop_front();
          if (out_ch.sample !== want.sample)
            report_mismatch($sformatf("sample got %0d expected %0d",
                                      out_ch.sample, want.sample));
          if (out_ch.active !== want.active)
            report_mismatch($sformatf("active got %b expected %b",
                                      out_ch.active, want.active));
        end
      end
      if (holdoff_req != 0) begin
        stall_left  = holdoff_req;
        holdoff_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offers one event, waits for its transfer, then predicts it. Valid is left
  // high so back-to-back events need no second assignment in the same step.
  task automatic send_event(input req_type_t kind, input logic [CYC_W-1:0] cycles);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.cycle_count <= cycles;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    voice_model_step(kind, cycles);
  endtask

  // Every event yields a result, so an empty queue plus the SETTLE wait means idle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_ENVELOPE:  env_reg    = value;
      CFG_NOISE:     noise_reg  = value;
      CFG_LENGTH_EN: len_en_reg = value[0];
      default: ;  // out of range, dropped by the block
    endcase
  endtask

  function automatic logic [CYC_W-1:0] pick_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return CYC_W'($urandom_range(0, (1 << CYC_W) - 1));
  endfunction

  // Event mix inside a note; length_bias pushes some notes to expiry.
  function automatic req_type_t pick_event(input int length_bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < length_bias)      return REQ_LENGTH;
    if (r < length_bias + 20) return REQ_ENVELOPE;
    if (r < length_bias + 23) return REQ_TRIGGER;
    return REQ_ADVANCE;
  endfunction

  // New settings between notes; slow clock shifts are kept rare so a later
  // switch to a short period does not leave a huge backlog of steps.
  task automatic program_random_settings();
    int         r;
    logic [7:0] env_v;
    logic [7:0] noise_v;
    r = $urandom_range(0, 99);
    env_v = (r < 12) ? 8'h00 : (r < 24) ? 8'hFF : 8'($urandom_range(0, 255));
    noise_v[7:4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 3));
    noise_v[3:0] = 4'($urandom_range(0, 15));
    set_register(CFG_ENVELOPE, env_v);
    set_register(CFG_NOISE, noise_v);
    set_register(CFG_LENGTH_EN, CFG_DATA_W'($urandom_range(0, 3) != 0));
    if ($urandom_range(0, 19) == 0) set_register(CFG_UNUSED, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corners: idle voice, converter off, both period bases, short mode, pace
  // zero, saturation at both ends, late envelope write, mid-count period
  // change, ignored register index, length ticks while disabled.
  task automatic test_event_corners();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_event(REQ_LENGTH, '0);      // nothing enabled yet
    send_event(REQ_ENVELOPE, '1);    // pace zero
    send_event(REQ_ADVANCE, '1);     // 31 steps at period 8, voice still off
    send_event(REQ_TRIGGER, '0);     // converter stays off, length reloads
    set_register(CFG_ENVELOPE, 8'hF0);
    set_register(CFG_LENGTH_EN, 8'h01);
    send_event(REQ_TRIGGER, '0);
    send_event(REQ_ADVANCE, '0);
    send_event(REQ_ADVANCE, '1);
    send_event(REQ_ENVELOPE, '0);
    send_event(REQ_LENGTH, '0);
    set_register(CFG_NOISE, 8'h0F);  // short mode, code 7
    send_event(REQ_ADVANCE, '1);
    send_event(REQ_ADVANCE, '1);
    set_register(CFG_ENVELOPE, 8'hF9);
    send_event(REQ_TRIGGER, '0);     // length already nonzero, kept
    send_event(REQ_ENVELOPE, '0);
    send_event(REQ_ENVELOPE, '0);    // pinned at 15
    set_register(CFG_ENVELOPE, 8'h11);
    send_event(REQ_TRIGGER, '0);
    set_register(CFG_ENVELOPE, 8'h00);
    send_event(REQ_ADVANCE, 8'd200); // converter stays on until next trigger
    set_register(CFG_ENVELOPE, 8'h11);
    send_event(REQ_ENVELOPE, '0);
    send_event(REQ_ENVELOPE, '0);    // pinned at 0
    set_register(CFG_NOISE, 8'hF7);  // longest period
    send_event(REQ_ADVANCE, '1);
    send_event(REQ_ADVANCE, '1);
    set_register(CFG_NOISE, 8'h00);
    send_event(REQ_ADVANCE, '0);     // backlog drains at period 8
    set_register(CFG_UNUSED, 8'hFF);
    send_event(REQ_ADVANCE, 8'd9);
    set_register(CFG_LENGTH_EN, 8'h00);
    send_event(REQ_LENGTH, '0);
    set_register(CFG_NOISE, 8'hFF);
    send_event(REQ_ADVANCE, '1);
  endtask

  // Mostly notes (trigger then a run of events), some register changes and
  // some unordered noise events.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_items);
    int sent;
    int r;
    int note_len;
    int length_bias;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        program_random_settings();
      end else if (r < 85) begin
        note_len    = $urandom_range(4, 90);
        length_bias = ($urandom_range(0, 3) == 0) ? 70 : 20;
        send_event(REQ_TRIGGER, pick_cycles());
        repeat (note_len) send_event(pick_event(length_bias), pick_cycles());
        sent += note_len + 1;
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_event(req_type_t'($urandom_range(0, 3)), pick_cycles());
          sent++;
        end
      end
    end
  endtask

  // Receiver goes quiet for a long stretch while events keep coming, so the
  // block holds a finished result and stops taking input.
  task automatic test_receiver_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_register(CFG_ENVELOPE, 8'hA2);
    set_register(CFG_NOISE, 8'h01);
    holdoff_req = 400;
    send_event(REQ_TRIGGER, '0);
    repeat (12) send_event(pick_event(20), pick_cycles());
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    mismatches     = 0;
    results_seen   = 0;
    holdoff_req    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    voice_model_reset();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_ENVELOPE;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_ADVANCE;
    in_ch.cycle_count <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_event_corners();
    test_random_traffic(0, 0, 500);    // no idling
    test_random_traffic(85, 0, 430);   // sparse sender
    test_random_traffic(0, 85, 430);   // slow receiver
    test_receiver_holdoff();
    test_random_traffic(6, 6, 430);    // light idling on both sides

    in_ch.valid <= 1'b0;
    waited = 0;
    while (expected_outputs.size() != 0 && waited < END_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (expected_outputs.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                expected_outputs.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/nce_pkg.sv
hw/rtl/nce_in_if.sv
hw/rtl/nce_out_if.sv
hw/rtl/nce_step_unit.sv
hw/rtl/noise_channel_lfsr_envelope.sv
hw/rtl/nce_checker.sv
sim/noise_channel_lfsr_envelope_tb.sv
